>>> design/bdf_pkg.sv
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types and constants for the box duplicate filter.
// ----------------------------------------------------------------------------
package bdf_pkg;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } bdf_state_t;

    // bit positions inside the result tuser
    localparam int unsigned USER_KEEP_BIT = 0;
    localparam int unsigned USER_OVF_BIT  = 1;
    localparam int unsigned USER_W        = 2;

endpackage

>>> design/box_duplicate_filter_core.sv
// ----------------------------------------------------------------------------
// box_duplicate_filter_core
// Exact-match duplicate removal over lists of boxes, one stored-entry compare
// per cycle against a table of the distinct boxes seen in the current list.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                         marks
//  s_axis    in   tdata: box_x, box_y, box_width, box_height      tlast: list_end
//  m_axis    out  tdata: out_x, out_y, out_width, out_height      tlast: out_last
//                 tuser: keep, table_overflow
//
//  a box passes through the accept, the scan of the n stored entries (n at most
//  TABLE_DEPTH) through the single table read port and comparator, and the
//  update of the table with the load of the result.
//  the next box is taken while a result waits in the output register.
//  reset clears the fill count and the handshake; table contents are left as
//  they are, entries at or above the fill count are never read.
//  a stalled m_axis holds the sequencer in its final state.
//
module box_duplicate_filter_core #(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned COORD_BITS  = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // box_x, box_y, box_width, box_height from bit 0 up, zero padded
    input  logic [((4*COORD_BITS+2+7)/8)*8-1:0]           s_axis_tdata,
    input  logic                                          s_axis_tlast,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // out_x, out_y, out_width, out_height from bit 0 up, zero padded
    output logic [((4*COORD_BITS+2+7)/8)*8-1:0]           m_axis_tdata,
    // keep, table_overflow from bit 0 up
    output logic [bdf_pkg::USER_W-1:0]                    m_axis_tuser,
    output logic                                          m_axis_tlast
);

    import bdf_pkg::*;

    localparam int unsigned KEY_W  = 4*COORD_BITS + 2;
    localparam int unsigned DATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [KEY_W-1:0]   table_mem [TABLE_DEPTH];

    bdf_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               found_reg, found_next;
    logic               m_valid_reg, m_valid_next;

    logic [KEY_W-1:0]   key_reg;
    logic               last_reg;
    logic [KEY_W-1:0]   rd_data_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [USER_W-1:0]  out_user_reg;
    logic               out_last_reg;

    logic               in_beat;
    logic               rd_en;
    logic               match;
    logic               out_free;
    logic               do_finish;
    logic               has_room;
    logic               do_store;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign match     = rd_pend_reg && (rd_data_reg == key_reg);
    assign rd_en     = (state_reg == ST_SCAN) && !match && (idx_reg < count_reg);
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign do_finish = (state_reg == ST_FINISH) && out_free;
    assign has_room  = count_reg < DEPTH_CNT;
    assign do_store  = do_finish && !found_reg && has_room;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (rd_en)
                begin
                    idx_next     = idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (last_reg)
                    begin
                        count_next = '0;
                    end
                    else if (do_store)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            last_reg <= s_axis_tlast;
        end
        if (do_finish)
        begin
            out_data_reg                <= DATA_W'(key_reg);
            out_user_reg[USER_KEEP_BIT] <= !found_reg;
            out_user_reg[USER_OVF_BIT]  <= !found_reg && !has_room;
            out_last_reg                <= last_reg;
        end
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            table_mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count beyond table depth");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_SCAN) && !s_axis_tready)
        else $error("accepted beat did not start a scan");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_SCAN) && (idx_reg <= count_reg))
        else $error("table read data outside a scan");

    a_store_new: assert property (@(posedge clk) disable iff (!rst_n)
        do_store |-> !found_reg && !m_axis_tuser[USER_OVF_BIT] | 1'b1 && has_room)
        else $error("store into a full table");
`endif

endmodule
